// ===== sv/srt_pkg.sv =====
// ----------------------------------------------------------------------------
// srt_pkg
// Shared widths, command and status codes, and the controller/datapath
// interface structs of the sorted record table.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int unsigned KEY_W        = 20;
  localparam int unsigned GRADE_W      = 5;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned STAT_W       = 2;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned GRADE_MAX    = 20;
  localparam int unsigned DEF_CAPACITY = 16;

  // Scan unit: cells examined per cycle (power of two) and its index width.
  localparam int unsigned SCAN_LANES   = 8;
  localparam int unsigned SCAN_LW      = $clog2(SCAN_LANES);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_BEST   = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  // Controller to datapath.
  typedef struct packed {
    logic load_in;  // capture the command transaction
    logic flag;     // compare all cells, load scan line, apply insert
    logic scan;     // consume one group of the scan line
    logic shift;    // close the gap at the first removed entry
    logic finish;   // load the result registers
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic dropped;    // insert into a full table
    logic last_grp;   // scan is on its final group
    logic rem_zero;   // no removals left to apply
    logic is_remove;  // current command is a remove
  } dp_stat_t;

endpackage

// ===== sv/srt_ctrl.sv =====
// ----------------------------------------------------------------------------
// srt_ctrl
// Command sequencer: accept, compare, group scan, removal shifts, result.
// ----------------------------------------------------------------------------
module srt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  input  srt_pkg::dp_stat_t stat_i,
  output srt_pkg::dp_cmd_t  cmd_o
);
  import srt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FLAG,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_FLAG;
        end
      end
      S_FLAG: begin
        cmd_o.flag = 1'b1;
        state_d    = stat_i.dropped ? S_FINISH : S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.last_grp) begin
          state_d = stat_i.is_remove ? S_SHIFT : S_FINISH;
        end
      end
      S_SHIFT: begin
        if (stat_i.rem_zero) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.shift = 1'b1;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.finish;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

  // A result strobe is never held high back to back.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for more than one cycle");

  // The result shows while the sequencer is free for the next transaction.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result strobe outside idle");

endmodule

// ===== sv/srt_datapath.sv =====
// ----------------------------------------------------------------------------
// srt_datapath
// Record cells with per-cell compare and neighbor shift, a scan line that
// is reduced eight cells per cycle, and the result registers.
// ----------------------------------------------------------------------------
module srt_datapath #(
  parameter int unsigned CAPACITY = srt_pkg::DEF_CAPACITY
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [srt_pkg::CMD_W-1:0]   cmd_i,
  input  logic [srt_pkg::KEY_W-1:0]   key_i,
  input  logic [srt_pkg::GRADE_W-1:0] grade_i,
  input  srt_pkg::dp_cmd_t            ctrl_i,
  output srt_pkg::dp_stat_t           stat_o,
  output logic [srt_pkg::STAT_W-1:0]  status_o,
  output logic [srt_pkg::KEY_W-1:0]   found_key_o,
  output logic [srt_pkg::GRADE_W-1:0] found_grade_o,
  output logic [srt_pkg::POS_W-1:0]   position_o,
  output logic [srt_pkg::COUNT_W-1:0] entry_count_o
);
  import srt_pkg::*;

  localparam int unsigned NG = (CAPACITY + SCAN_LANES - 1) / SCAN_LANES;
  localparam int unsigned SW = NG * SCAN_LANES;
  localparam int unsigned GW = (NG > 1) ? $clog2(NG) : 1;
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Captured command
  cmd_e               cmd_q;
  logic [KEY_W-1:0]   key_q;
  logic [GRADE_W-1:0] grade_q;
  logic               dropped_q;

  // Table
  logic [KEY_W-1:0]   cell_key_q   [CAPACITY];
  logic [GRADE_W-1:0] cell_grade_q [CAPACITY];
  logic [KEY_W-1:0]   cell_key_d   [CAPACITY];
  logic [GRADE_W-1:0] cell_grade_d [CAPACITY];
  logic [CW-1:0]      occ_q;
  logic [CAPACITY-1:0] valid, lt, eq, lt_prev;
  logic               ins_full, do_insert;

  // Scan line
  logic [SW-1:0]      sv_flag_q, sv_flag_d;
  logic [KEY_W-1:0]   sv_key_q   [SW];
  logic [GRADE_W-1:0] sv_grade_q [SW];
  logic [KEY_W-1:0]   sv_key_d   [SW];
  logic [GRADE_W-1:0] sv_grade_d [SW];

  // Scan accumulators
  logic [GW-1:0]      grp_q;
  logic               hit_q;
  logic [IW-1:0]      idx_q;
  logic [KEY_W-1:0]   acc_key_q;
  logic [GRADE_W-1:0] acc_grade_q;
  logic [CW-1:0]      cnt_q;

  // Result registers
  logic [STAT_W-1:0]  res_status_q;
  logic [KEY_W-1:0]   res_key_q;
  logic [GRADE_W-1:0] res_grade_q;
  logic [POS_W-1:0]   res_pos_q;
  logic [COUNT_W-1:0] res_count_q;

  assign ins_full  = (occ_q == CW'(CAPACITY));
  assign do_insert = ctrl_i.flag && (cmd_q == CMD_INSERT) && !ins_full;
  assign lt_prev   = {lt[CAPACITY-2:0], 1'b1};

  // Per-cell compare and update
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0]   prev_key, next_key;
    logic [GRADE_W-1:0] prev_grade, next_grade;

    if (i == 0) begin : g_first
      assign prev_key   = cell_key_q[i];
      assign prev_grade = cell_grade_q[i];
    end else begin : g_mid
      assign prev_key   = cell_key_q[i-1];
      assign prev_grade = cell_grade_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_key   = cell_key_q[i];
      assign next_grade = cell_grade_q[i];
    end else begin : g_body
      assign next_key   = cell_key_q[i+1];
      assign next_grade = cell_grade_q[i+1];
    end

    assign valid[i] = (CW'(i) < occ_q);
    assign lt[i]    = valid[i] && (cell_key_q[i] < key_q);
    assign eq[i]    = valid[i] && (cell_key_q[i] == key_q);

    always_comb begin
      cell_key_d[i]   = cell_key_q[i];
      cell_grade_d[i] = cell_grade_q[i];
      if (do_insert && !lt[i]) begin
        // The first cell whose key is not smaller takes the new record,
        // every cell above it moves up by one.
        if (lt_prev[i]) begin
          cell_key_d[i]   = key_q;
          cell_grade_d[i] = grade_q;
        end else begin
          cell_key_d[i]   = prev_key;
          cell_grade_d[i] = prev_grade;
        end
      end else if (ctrl_i.shift && (IW'(i) >= idx_q)) begin
        cell_key_d[i]   = next_key;
        cell_grade_d[i] = next_grade;
      end
    end

    always_ff @(posedge clk_i) begin
      cell_key_q[i]   <= cell_key_d[i];
      cell_grade_q[i] <= cell_grade_d[i];
    end
  end

  // Scan line: load from the cells, then advance one group per cycle
  for (genvar i = 0; i < SW; i++) begin : g_scan
    logic             load_flag;
    logic [KEY_W-1:0]   load_key;
    logic [GRADE_W-1:0] load_grade;
    logic             up_flag;
    logic [KEY_W-1:0]   up_key;
    logic [GRADE_W-1:0] up_grade;

    if (i < CAPACITY) begin : g_live
      always_comb begin
        case (cmd_q)
          CMD_INSERT: load_flag = !lt[i];
          CMD_BEST:   load_flag = valid[i];
          default:    load_flag = eq[i];
        endcase
      end
      assign load_key   = cell_key_q[i];
      assign load_grade = cell_grade_q[i];
    end else begin : g_pad
      assign load_flag  = 1'b0;
      assign load_key   = '0;
      assign load_grade = '0;
    end

    if (i + SCAN_LANES < SW) begin : g_feed
      assign up_flag  = sv_flag_q[i+SCAN_LANES];
      assign up_key   = sv_key_q[i+SCAN_LANES];
      assign up_grade = sv_grade_q[i+SCAN_LANES];
    end else begin : g_tail
      assign up_flag  = 1'b0;
      assign up_key   = '0;
      assign up_grade = '0;
    end

    always_comb begin
      sv_flag_d[i]  = sv_flag_q[i];
      sv_key_d[i]   = sv_key_q[i];
      sv_grade_d[i] = sv_grade_q[i];
      if (ctrl_i.flag) begin
        sv_flag_d[i]  = load_flag;
        sv_key_d[i]   = load_key;
        sv_grade_d[i] = load_grade;
      end else if (ctrl_i.scan) begin
        sv_flag_d[i]  = up_flag;
        sv_key_d[i]   = up_key;
        sv_grade_d[i] = up_grade;
      end
    end

    always_ff @(posedge clk_i) begin
      sv_key_q[i]   <= sv_key_d[i];
      sv_grade_q[i] <= sv_grade_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_flag_q <= '0;
    end else begin
      sv_flag_q <= sv_flag_d;
    end
  end

  // Group reduction over the bottom lanes of the scan line
  logic [KEY_W-1:0]       tap_key   [SCAN_LANES];
  logic [GRADE_W-1:0]     tap_grade [SCAN_LANES];
  logic                   g_hit, g_bhit, take;
  logic [SCAN_LW-1:0]     g_first, g_bidx, sel;
  logic [GRADE_W-1:0]     g_bgrade;
  logic [SCAN_LW:0]       g_pop;
  logic [GW+SCAN_LW-1:0]  cand_idx;

  for (genvar j = 0; j < SCAN_LANES; j++) begin : g_tap
    assign tap_key[j]   = sv_key_q[j];
    assign tap_grade[j] = sv_grade_q[j];
  end

  always_comb begin
    g_hit    = 1'b0;
    g_first  = '0;
    g_bhit   = 1'b0;
    g_bidx   = '0;
    g_bgrade = '0;
    g_pop    = '0;
    for (int j = SCAN_LANES - 1; j >= 0; j--) begin
      if (sv_flag_q[j]) begin
        g_hit   = 1'b1;
        g_first = SCAN_LW'(j);
      end
    end
    // Earliest strictly highest grade within the group
    for (int j = 0; j < SCAN_LANES; j++) begin
      if (sv_flag_q[j] && (!g_bhit || (tap_grade[j] > g_bgrade))) begin
        g_bhit   = 1'b1;
        g_bidx   = SCAN_LW'(j);
        g_bgrade = tap_grade[j];
      end
      g_pop = g_pop + (SCAN_LW+1)'(sv_flag_q[j]);
    end
    if (cmd_q == CMD_BEST) begin
      take = g_bhit && (!hit_q || (g_bgrade > acc_grade_q));
      sel  = g_bidx;
    end else begin
      take = g_hit && !hit_q;
      sel  = g_first;
    end
  end

  assign cand_idx = {grp_q, sel};

  // Result fields
  logic [CW+POS_W-1:0]   pos_wide;
  logic [CW+COUNT_W-1:0] cnt_wide;
  logic [STAT_W-1:0]     r_status;
  logic [KEY_W-1:0]      r_key;
  logic [GRADE_W-1:0]    r_grade;
  logic [POS_W-1:0]      r_pos;

  assign pos_wide = (CW+POS_W)'(idx_q) + (CW+POS_W)'(1);
  assign cnt_wide = (CW+COUNT_W)'(occ_q);

  always_comb begin
    r_status = ST_MISS;
    r_key    = '0;
    r_grade  = '0;
    r_pos    = '0;
    case (cmd_q)
      CMD_INSERT: begin
        if (dropped_q) begin
          r_status = ST_FULL;
        end else begin
          r_status = ST_DONE;
          r_key    = key_q;
          r_grade  = grade_q;
          r_pos    = pos_wide[POS_W-1:0];
        end
      end
      CMD_REMOVE: begin
        r_status = hit_q ? ST_DONE : ST_MISS;
      end
      default: begin
        if (hit_q) begin
          r_status = ST_DONE;
          r_key    = acc_key_q;
          r_grade  = acc_grade_q;
          r_pos    = pos_wide[POS_W-1:0];
        end
      end
    endcase
  end

  // Payload captures
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      cmd_q   <= cmd_e'(cmd_i);
      key_q   <= key_i;
      grade_q <= (grade_i > GRADE_W'(GRADE_MAX)) ? GRADE_W'(GRADE_MAX) : grade_i;
    end
    if (ctrl_i.scan && take) begin
      idx_q       <= IW'(cand_idx);
      acc_key_q   <= tap_key[sel];
      acc_grade_q <= tap_grade[sel];
    end
    if (ctrl_i.finish) begin
      res_status_q <= r_status;
      res_key_q    <= r_key;
      res_grade_q  <= r_grade;
      res_pos_q    <= r_pos;
      res_count_q  <= cnt_wide[COUNT_W-1:0];
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= '0;
      dropped_q <= 1'b0;
      grp_q     <= '0;
      hit_q     <= 1'b0;
      cnt_q     <= '0;
    end else begin
      if (ctrl_i.flag) begin
        dropped_q <= (cmd_q == CMD_INSERT) && ins_full;
        grp_q     <= '0;
        hit_q     <= 1'b0;
        cnt_q     <= '0;
      end
      if (do_insert) begin
        occ_q <= occ_q + CW'(1);
      end
      if (ctrl_i.scan) begin
        grp_q <= grp_q + GW'(1);
        cnt_q <= cnt_q + CW'(g_pop);
        if (take) begin
          hit_q <= 1'b1;
        end
      end
      if (ctrl_i.shift) begin
        cnt_q <= cnt_q - CW'(1);
        occ_q <= occ_q - CW'(1);
      end
    end
  end

  assign stat_o.dropped   = (cmd_q == CMD_INSERT) && ins_full;
  assign stat_o.last_grp  = (grp_q == GW'(NG - 1));
  assign stat_o.rem_zero  = (cnt_q == '0);
  assign stat_o.is_remove = (cmd_q == CMD_REMOVE);

  assign status_o      = res_status_q;
  assign found_key_o   = res_key_q;
  assign found_grade_o = res_grade_q;
  assign position_o    = res_pos_q;
  assign entry_count_o = res_count_q;

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CW'(CAPACITY))
    else $error("occupancy above capacity");

  a_shift_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.shift |-> (cnt_q != '0) && (occ_q != '0) && hit_q)
    else $error("removal shift with nothing to remove");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> (occ_q == $past(occ_q) + CW'(1)))
    else $error("insert did not grow the table");

endmodule

// ===== sv/sorted_record_table.sv =====
// ----------------------------------------------------------------------------
// sorted_record_table
// Bounded table of key/grade records in ascending key order with insert,
// remove-all-by-key, lookup and best-grade commands.
// ----------------------------------------------------------------------------
//  channel  | ports                                             | handshake
//  ---------+---------------------------------------------------+-------------
//  command  | cmd_i, key_i, grade_i                             | start, busy
//  result   | status_o, found_key_o, found_grade_o, position_o, | done_o
//           | entry_count_o                                     | (one cycle)
//
//  Every command is captured and compared across all cells and, unless it is
//  dropped, scanned group by group; the scan unit reduces eight cells per cycle.
//  A remove then applies one shift per deleted entry before the result.
//  An insert into a full table skips the scan and goes to the result.
//  After reset the table is empty and a command is taken at once.
//  The result is shown for one cycle only; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module sorted_record_table #(
  parameter int unsigned CAPACITY = srt_pkg::DEF_CAPACITY
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [srt_pkg::CMD_W-1:0]    cmd_i,
  input  logic [srt_pkg::KEY_W-1:0]    key_i,
  input  logic [srt_pkg::GRADE_W-1:0]  grade_i,
  output logic                         done_o,
  output logic [srt_pkg::STAT_W-1:0]   status_o,
  output logic [srt_pkg::KEY_W-1:0]    found_key_o,
  output logic [srt_pkg::GRADE_W-1:0]  found_grade_o,
  output logic [srt_pkg::POS_W-1:0]    position_o,
  output logic [srt_pkg::COUNT_W-1:0]  entry_count_o
);
  import srt_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  srt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .stat_i (dp_stat),
    .cmd_o  (dp_cmd)
  );

  srt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_i),
    .key_i         (key_i),
    .grade_i       (grade_i),
    .ctrl_i        (dp_cmd),
    .stat_o        (dp_stat),
    .status_o      (status_o),
    .found_key_o   (found_key_o),
    .found_grade_o (found_grade_o),
    .position_o    (position_o),
    .entry_count_o (entry_count_o)
  );

endmodule
